### design/crlu_pkg.sv
// ----------------------------------------------------------------------------
// crlu_pkg - condition register unit package
// Shared command codes, logic-op subopcodes and controller command struct.
// ----------------------------------------------------------------------------
package crlu_pkg;

	// Instruction kinds carried in the cmd field
	typedef enum logic [1:0] {
		OP_MFCR    = 2'd0,
		OP_MTCRF   = 2'd1,
		OP_MCRF    = 2'd2,
		OP_CRLOGIC = 2'd3
	} crlu_op_t;

	// Extended opcodes of the CR logic ops
	localparam logic [9:0] SUBOP_AND  = 10'd257;
	localparam logic [9:0] SUBOP_ANDC = 10'd129;
	localparam logic [9:0] SUBOP_EQV  = 10'd289;
	localparam logic [9:0] SUBOP_NAND = 10'd225;
	localparam logic [9:0] SUBOP_NOR  = 10'd33;
	localparam logic [9:0] SUBOP_OR   = 10'd449;
	localparam logic [9:0] SUBOP_ORC  = 10'd417;
	localparam logic [9:0] SUBOP_XOR  = 10'd193;

	// Output buffer occupancy
	typedef enum logic {
		ST_EMPTY = 1'b0,
		ST_FULL  = 1'b1
	} crlu_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;  // execute the request beat and capture its result
	} crlu_cmd_t;

endpackage

### design/crlu_req_if.sv
// ----------------------------------------------------------------------------
// crlu_req_if - request channel
// Valid/ready channel carrying one instruction per beat.
// ----------------------------------------------------------------------------
interface crlu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] source_word;
	logic [7:0]  field_mask;
	logic [2:0]  src_field;
	logic [2:0]  dst_field;
	logic [4:0]  bit_a;
	logic [4:0]  bit_b;
	logic [4:0]  bit_d;
	logic [9:0]  logic_subop;

	modport source (
		output valid, cmd, source_word, field_mask, src_field, dst_field,
		       bit_a, bit_b, bit_d, logic_subop,
		input  ready
	);
	modport sink (
		input  valid, cmd, source_word, field_mask, src_field, dst_field,
		       bit_a, bit_b, bit_d, logic_subop,
		output ready
	);
endinterface

### design/crlu_rsp_if.sv
// ----------------------------------------------------------------------------
// crlu_rsp_if - response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface crlu_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] dest_word;
	logic        dest_valid;
	logic        bad_subop;

	modport source (
		output valid, dest_word, dest_valid, bad_subop,
		input  ready
	);
	modport sink (
		input  valid, dest_word, dest_valid, bad_subop,
		output ready
	);
endinterface

### design/crlu_ctrl.sv
// ----------------------------------------------------------------------------
// crlu_ctrl - condition register unit controller
// Tracks the result buffer and issues the load command per accepted beat.
// ----------------------------------------------------------------------------
module crlu_ctrl
	import crlu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output crlu_cmd_t cmd
);

	crlu_state_t state_q;
	crlu_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd.load  = 1'b0;
		unique case (state_q)
			ST_EMPTY: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
				if (req_valid) begin
					state_d = ST_FULL;
				end
			end
			ST_FULL: begin
				// result leaving frees the buffer for a new beat in the same cycle
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				cmd.load  = req_valid && rsp_ready;
				if (rsp_ready && !req_valid) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

endmodule

### design/crlu_datapath.sv
// ----------------------------------------------------------------------------
// crlu_datapath - condition register unit datapath
// Holds the packed CR, executes one instruction on load, registers the result.
// ----------------------------------------------------------------------------
module crlu_datapath
	import crlu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  crlu_cmd_t   cmd,
	input  logic [1:0]  op,
	input  logic [31:0] source_word,
	input  logic [7:0]  field_mask,
	input  logic [2:0]  src_field,
	input  logic [2:0]  dst_field,
	input  logic [4:0]  bit_a,
	input  logic [4:0]  bit_b,
	input  logic [4:0]  bit_d,
	input  logic [9:0]  logic_subop,
	output logic [31:0] dest_word,
	output logic        dest_valid,
	output logic        bad_subop
);

	// Packed CR: field 0 in bits 31:28, CR bit n sits at word bit 31-n
	logic [31:0] cr_q;
	logic [31:0] cr_d;
	logic [31:0] word_d;
	logic        valid_d;
	logic        bad_d;
	logic        opa;
	logic        opb;
	logic        res;
	logic [31:0] dest_word_q;
	logic        dest_valid_q;
	logic        bad_subop_q;

	assign opa = cr_q[~bit_a];
	assign opb = cr_q[~bit_b];

	always_comb begin
		res   = opa;
		bad_d = 1'b0;
		unique case (logic_subop)
			SUBOP_AND:  res = opa & opb;
			SUBOP_ANDC: res = opa & ~opb;
			SUBOP_EQV:  res = ~(opa ^ opb);
			SUBOP_NAND: res = ~(opa & opb);
			SUBOP_NOR:  res = ~(opa | opb);
			SUBOP_OR:   res = opa | opb;
			SUBOP_ORC:  res = opa | ~opb;
			SUBOP_XOR:  res = opa ^ opb;
			default: begin
				res   = opa;
				bad_d = 1'b1;
			end
		endcase
	end

	always_comb begin
		cr_d    = cr_q;
		word_d  = '0;
		valid_d = 1'b0;
		unique case (crlu_op_t'(op))
			OP_MFCR: begin
				word_d  = cr_q;
				valid_d = 1'b1;
			end
			OP_MTCRF: begin
				for (int i = 0; i < 8; i++) begin
					if (field_mask[i]) begin
						cr_d[4*i +: 4] = source_word[4*i +: 4];
					end
				end
			end
			OP_MCRF: begin
				cr_d[{~dst_field, 2'b00} +: 4] = cr_q[{~src_field, 2'b00} +: 4];
			end
			OP_CRLOGIC: begin
				cr_d[~bit_d] = res;
			end
			default: begin
				cr_d = cr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q <= '0;
		end else if (cmd.load) begin
			cr_q <= cr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dest_word_q  <= word_d;
			dest_valid_q <= valid_d;
			bad_subop_q  <= bad_d && (crlu_op_t'(op) == OP_CRLOGIC);
		end
	end

	assign dest_word  = dest_word_q;
	assign dest_valid = dest_valid_q;
	assign bad_subop  = bad_subop_q;

endmodule

### design/condition_register_unit_top.sv
// ----------------------------------------------------------------------------
// condition_register_unit_top - PowerPC-style condition register unit
// A result is offered in the cycle after its request beat is accepted.
// Throughput: one instruction per cycle while the sink keeps rsp_ready high;
//   the single result buffer sets this, taking a beat when empty or draining.
// Reset: arst_n clears the CR to all zero and empties the result buffer.
// ----------------------------------------------------------------------------
module condition_register_unit_top
	import crlu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	crlu_req_if.sink   req,
	crlu_rsp_if.source rsp
);

	// Controller/datapath command bundle
	crlu_cmd_t cmd;

	// Controller: owns the handshake on both channels. It decides when a
	// request beat is taken and whether a result is pending in the buffer.
	crlu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Datapath: the CR itself plus the result register. On load it reads the
	// CR (operands and the mfcr word come from the value before this beat),
	// writes back the updated CR and captures the result fields.
	crlu_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (req.cmd),
		.source_word (req.source_word),
		.field_mask  (req.field_mask),
		.src_field   (req.src_field),
		.dst_field   (req.dst_field),
		.bit_a       (req.bit_a),
		.bit_b       (req.bit_b),
		.bit_d       (req.bit_d),
		.logic_subop (req.logic_subop),
		.dest_word   (rsp.dest_word),
		.dest_valid  (rsp.dest_valid),
		.bad_subop   (rsp.bad_subop)
	);

`ifndef SYNTHESIS
	// Only mfcr produces a general register write; all else returns zero
	a_no_dest_unless_mfcr: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.cmd != OP_MFCR)) |=>
		(!rsp.dest_valid && (rsp.dest_word == 32'd0)))
		else $error("dest word flagged for a non-mfcr instruction");

	// Invalid subopcode flag belongs to CR logic ops only
	a_bad_only_logic: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.cmd != OP_CRLOGIC)) |=> !rsp.bad_subop)
		else $error("bad_subop raised outside a CR logic op");

	// A result appears only after a request beat was taken
	a_result_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(req.valid && req.ready))
		else $error("result offered without an accepted request beat");
`endif

endmodule

### tb/condition_register_unit_top_tb.sv
// ----------------------------------------------------------------------------
// condition_register_unit_top_tb - condition register unit testbench
// Drives instruction beats into the unit and keeps a shadow copy of the
// condition register. Each response beat is checked against the predicted
// result. A short directed part comes first, then a long random mix under
// random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module condition_register_unit_top_tb;
	import crlu_pkg::*;

	localparam int unsigned RANDOM_INSTRS = 1950;
	localparam int unsigned PHASE_LEN     = 150;
	// Slowest legal run: about 1975 beats, each with the longest source gap,
	// the longest sink stall and its passage through the unit. Allow several
	// times that.
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 4;

	// One instruction as it travels on the request channel
	typedef struct {
		crlu_op_t    op;
		logic [31:0] source_word;
		logic [7:0]  field_mask;
		logic [2:0]  src_field;
		logic [2:0]  dst_field;
		logic [4:0]  bit_a;
		logic [4:0]  bit_b;
		logic [4:0]  bit_d;
		logic [9:0]  logic_subop;
	} cr_instr_t;

	// One result as it travels on the response channel
	typedef struct {
		logic [31:0] dest_word;
		logic        dest_valid;
		logic        bad_subop;
	} cr_result_t;

	logic clk;
	logic arst_n;

	crlu_req_if req_ch ();
	crlu_rsp_if rsp_ch ();

	condition_register_unit_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow condition register: field 0 is the most significant field
	logic [3:0]  shadow_cr [8];
	// Results owed by the unit, oldest first
	cr_result_t  cr_results_due [$];
	cr_result_t  due;
	int unsigned failures;
	int unsigned cycle_count;
	// Set to run a stretch with neither side idling
	bit          steady_flow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw the wait before the next beat on either side.
	function automatic int unsigned idle_cycles();
		if (steady_flow || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [9:0] known_subop(input int unsigned idx);
		case (idx)
			0: return SUBOP_AND;
			1: return SUBOP_ANDC;
			2: return SUBOP_EQV;
			3: return SUBOP_NAND;
			4: return SUBOP_NOR;
			5: return SUBOP_OR;
			6: return SUBOP_ORC;
			default: return SUBOP_XOR;
		endcase
	endfunction

	// Build an instruction of the given kind with every field random; the
	// fields that this kind ignores still carry noise.
	function automatic cr_instr_t random_instr(input crlu_op_t op);
		cr_instr_t ins;
		ins.op          = op;
		ins.source_word = $urandom;
		ins.field_mask  = 8'($urandom);
		ins.src_field   = 3'($urandom);
		ins.dst_field   = 3'($urandom);
		ins.bit_a       = 5'($urandom);
		ins.bit_b       = 5'($urandom);
		ins.bit_d       = 5'($urandom);
		// Mostly known subopcodes, the rest anywhere in the 10-bit space
		if ($urandom_range(0, 3) == 0)
			ins.logic_subop = 10'($urandom);
		else
			ins.logic_subop = known_subop($urandom_range(0, 7));
		return ins;
	endfunction

	// Execute one instruction on the shadow CR and return the result the
	// unit owes for it.
	function automatic cr_result_t execute_on_shadow_cr(input cr_instr_t ins);
		cr_result_t res;
		logic       a;
		logic       b;
		logic       r;
		res.dest_word  = '0;
		res.dest_valid = 1'b0;
		res.bad_subop  = 1'b0;
		case (ins.op)
			OP_MFCR: begin
				for (int i = 0; i < 8; i++)
					res.dest_word[31 - 4 * i -: 4] = shadow_cr[i];
				res.dest_valid = 1'b1;
			end
			OP_MTCRF: begin
				for (int i = 0; i < 8; i++)
					if (ins.field_mask[7 - i])
						shadow_cr[i] = ins.source_word[31 - 4 * i -: 4];
			end
			OP_MCRF: begin
				shadow_cr[ins.dst_field] = shadow_cr[ins.src_field];
			end
			default: begin
				// Bit n sits at position 3 - (n mod 4) of field n / 4
				a = shadow_cr[ins.bit_a[4:2]][3 - ins.bit_a[1:0]];
				b = shadow_cr[ins.bit_b[4:2]][3 - ins.bit_b[1:0]];
				case (ins.logic_subop)
					SUBOP_AND:  r = a & b;
					SUBOP_ANDC: r = a & ~b;
					SUBOP_EQV:  r = ~(a ^ b);
					SUBOP_NAND: r = ~(a & b);
					SUBOP_NOR:  r = ~(a | b);
					SUBOP_OR:   r = a | b;
					SUBOP_ORC:  r = a | ~b;
					SUBOP_XOR:  r = a ^ b;
					default: begin
						// Unknown code: copy bit A and flag it
						r = a;
						res.bad_subop = 1'b1;
					end
				endcase
				shadow_cr[ins.bit_d[4:2]][3 - ins.bit_d[1:0]] = r;
			end
		endcase
		return res;
	endfunction

	// Send one instruction beat. Enter and leave at a falling edge; keep
	// valid high across back-to-back beats.
	task automatic send_instr(input cr_instr_t ins);
		int unsigned gap;
		gap = idle_cycles();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.cmd         <= ins.op;
		req_ch.source_word <= ins.source_word;
		req_ch.field_mask  <= ins.field_mask;
		req_ch.src_field   <= ins.src_field;
		req_ch.dst_field   <= ins.dst_field;
		req_ch.bit_a       <= ins.bit_a;
		req_ch.bit_b       <= ins.bit_b;
		req_ch.bit_d       <= ins.bit_d;
		req_ch.logic_subop <= ins.logic_subop;
		req_ch.valid       <= 1'b1;
		// Hold the beat until the unit takes it
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		cr_results_due.push_back(execute_on_shadow_cr(ins));
		@(negedge clk);
	endtask

	task automatic send_mfcr();
		send_instr(random_instr(OP_MFCR));
	endtask

	task automatic send_mtcrf(input logic [7:0] mask, input logic [31:0] word);
		cr_instr_t ins;
		ins             = random_instr(OP_MTCRF);
		ins.field_mask  = mask;
		ins.source_word = word;
		send_instr(ins);
	endtask

	task automatic send_mcrf(input logic [2:0] src, input logic [2:0] dst);
		cr_instr_t ins;
		ins           = random_instr(OP_MCRF);
		ins.src_field = src;
		ins.dst_field = dst;
		send_instr(ins);
	endtask

	task automatic send_crlogic(input logic [9:0] subop, input logic [4:0] a,
	                            input logic [4:0] b, input logic [4:0] d);
		cr_instr_t ins;
		ins             = random_instr(OP_CRLOGIC);
		ins.logic_subop = subop;
		ins.bit_a       = a;
		ins.bit_b       = b;
		ins.bit_d       = d;
		send_instr(ins);
	endtask

	// A read right after reset must return an all-zero CR.
	task automatic test_reset_state();
		send_mfcr();
	endtask

	// Full mask, empty mask, the end fields alone and a scattered mask.
	task automatic test_masked_move();
		send_mtcrf(8'hFF, 32'hFFFF_FFFF);
		send_mfcr();
		send_mtcrf(8'h00, 32'h1234_5678);
		send_mtcrf(8'h81, 32'h0000_0000);
		send_mtcrf(8'h5A, 32'hA5C3_96E1);
		send_mfcr();
	endtask

	// Copy onto itself, then between the end fields, then from field 7 to 2.
	task automatic test_field_copy();
		send_mcrf(3'd3, 3'd3);
		send_mcrf(3'd0, 3'd7);
		send_mcrf(3'd7, 3'd2);
		send_mfcr();
	endtask

	// Run each known op once; let the destination share a bit with A, then B.
	task automatic test_logic_ops();
		logic [4:0] d;
		for (int i = 0; i < 8; i++) begin
			if (i == 2)
				d = 5'(4 * i);
			else if (i == 3)
				d = 5'(31 - i);
			else
				d = 5'(4 * i + 2);
			send_crlogic(known_subop(i), 5'(4 * i), 5'(31 - i), d);
		end
		send_mfcr();
	endtask

	// Unknown codes at both ends of the subopcode range.
	task automatic test_unknown_subop();
		send_crlogic(10'd0, 5'd5, 5'd0, 5'd5);
		send_crlogic(10'd1023, 5'd31, 5'd9, 5'd0);
		send_mfcr();
	endtask

	// Long random mix; switch between idling and steady flow per phase.
	task automatic test_random_mix();
		int unsigned pick;
		crlu_op_t    op;
		for (int unsigned n = 0; n < RANDOM_INSTRS; n++) begin
			if (n % PHASE_LEN == 0)
				steady_flow = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 5)
				op = OP_MFCR;
			else if (pick < 9)
				op = OP_MTCRF;
			else if (pick < 13)
				op = OP_MCRF;
			else
				op = OP_CRLOGIC;
			send_instr(random_instr(op));
		end
		steady_flow = 1'b0;
	endtask

	// Stimulus: reset once, run the tests, drain, report.
	initial begin
		arst_n             = 1'b0;
		steady_flow        = 1'b0;
		failures           = 0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = OP_MFCR;
		req_ch.source_word = '0;
		req_ch.field_mask  = '0;
		req_ch.src_field   = '0;
		req_ch.dst_field   = '0;
		req_ch.bit_a       = '0;
		req_ch.bit_b       = '0;
		req_ch.bit_d       = '0;
		req_ch.logic_subop = '0;
		for (int i = 0; i < 8; i++)
			shadow_cr[i] = 4'h0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_masked_move();
		test_field_copy();
		test_logic_ops();
		test_unknown_subop();
		test_random_mix();

		req_ch.valid <= 1'b0;
		// Wait for every owed result, then drain for strays
		while (cr_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Response sink: stall a random number of cycles before each beat, with
	// steady-flow stretches where it never stalls.
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles();
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Check each accepted response beat against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (cr_results_due.size() == 0) begin
				$error("response beat with no result owed: dest_word=%h", rsp_ch.dest_word);
				failures++;
			end else begin
				due = cr_results_due.pop_front();
				if (rsp_ch.dest_word !== due.dest_word) begin
					$error("dest_word: expected %h, got %h", due.dest_word,
					       rsp_ch.dest_word);
					failures++;
				end
				if (rsp_ch.dest_valid !== due.dest_valid) begin
					$error("dest_valid: expected %b, got %b", due.dest_valid,
					       rsp_ch.dest_valid);
					failures++;
				end
				if (rsp_ch.bad_subop !== due.bad_subop) begin
					$error("bad_subop: expected %b, got %b", due.bad_subop,
					       rsp_ch.bad_subop);
					failures++;
				end
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
